// ===== hdl/spd_pkg.sv =====
// Shared types, character codes and the hex digit helper for the
// strict percent decoder. No dependencies.
`default_nettype none
package spd_pkg;

  localparam logic [7:0] CHAR_PERCENT  = 8'h25;
  localparam logic [7:0] CHAR_PLUS     = 8'h2B;
  localparam logic [7:0] CHAR_QUESTION = 8'h3F;
  localparam logic [7:0] CHAR_SPACE    = 8'h20;
  localparam logic [7:0] CHAR_0        = 8'h30;
  localparam logic [7:0] CHAR_9        = 8'h39;
  localparam logic [7:0] CHAR_UA       = 8'h41;
  localparam logic [7:0] CHAR_UF       = 8'h46;
  localparam logic [7:0] CHAR_LA       = 8'h61;
  localparam logic [7:0] CHAR_LF       = 8'h66;
  localparam logic [7:0] HEX_TEN       = 8'd10;

  localparam int unsigned CFG_AW = 3;
  localparam logic REG_PLUS_SPACE = 1'b0;

  typedef enum logic [3:0] {
    PH_NORMAL = 4'b0001,
    PH_HIGH   = 4'b0010,
    PH_LOW    = 4'b0100,
    PH_DROP   = 4'b1000
  } phase_t;

  typedef struct packed {
    phase_t     phase;
    logic [3:0] high_nib;
    logic       query_seen;
  } dec_state_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
    logic       err;
  } dec_result_t;

  // {is_hex, value}
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [7:0] v;
    v = 8'd0;
    if (b >= CHAR_0 && b <= CHAR_9) begin
      v = b - CHAR_0;
      return {1'b1, v[3:0]};
    end
    if (b >= CHAR_UA && b <= CHAR_UF) begin
      v = b - CHAR_UA + HEX_TEN;
      return {1'b1, v[3:0]};
    end
    if (b >= CHAR_LA && b <= CHAR_LF) begin
      v = b - CHAR_LA + HEX_TEN;
      return {1'b1, v[3:0]};
    end
    return 5'd0;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/spd_decode.sv =====
// Next-state and result logic for one byte of the percent decoder.
// Depends on spd_pkg.
`default_nettype none
module spd_decode (
  input  wire spd_pkg::dec_state_t  cur,
  input  wire logic [7:0]           in_byte,
  input  wire logic                 in_last,
  input  wire logic                 plus_space_en,
  output spd_pkg::dec_state_t       nxt,
  output spd_pkg::dec_result_t      res
);
  import spd_pkg::*;

  logic [4:0] hv;
  logic       fail;

  assign hv = hex_value(in_byte);

  always_comb begin
    nxt  = cur;
    res  = '0;
    fail = 1'b0;
    case (cur.phase)
      PH_DROP: begin
        if (in_last) begin
          nxt = '{phase: PH_NORMAL, high_nib: 4'd0, query_seen: 1'b0};
        end
      end
      PH_HIGH: begin
        if (!hv[4] || in_last) begin
          fail = 1'b1;
        end else begin
          nxt.high_nib = hv[3:0];
          nxt.phase    = PH_LOW;
        end
      end
      PH_LOW: begin
        if (!hv[4]) begin
          fail = 1'b1;
        end else begin
          res.valid    = 1'b1;
          res.data     = {cur.high_nib, hv[3:0]};
          res.last     = in_last;
          nxt.phase    = PH_NORMAL;
          nxt.high_nib = 4'd0;
          if (in_last) nxt.query_seen = 1'b0;
        end
      end
      PH_NORMAL: begin
        if (in_byte == CHAR_PERCENT) begin
          if (in_last) fail = 1'b1;
          else nxt.phase = PH_HIGH;
        end else begin
          res.valid = 1'b1;
          res.data  = in_byte;
          res.last  = in_last;
          if (in_byte == CHAR_QUESTION) begin
            nxt.query_seen = 1'b1;
          end else if (in_byte == CHAR_PLUS && cur.query_seen && plus_space_en) begin
            res.data = CHAR_SPACE;
          end
          if (in_last) begin
            nxt = '{phase: PH_NORMAL, high_nib: 4'd0, query_seen: 1'b0};
          end
        end
      end
      default: begin
        nxt = '{phase: PH_NORMAL, high_nib: 4'd0, query_seen: 1'b0};
      end
    endcase

    // error beat: zero data, marked last; drop the rest unless this was the end
    if (fail) begin
      res = '{valid: 1'b1, data: 8'd0, last: 1'b1, err: 1'b1};
      if (in_last) nxt = '{phase: PH_NORMAL, high_nib: 4'd0, query_seen: 1'b0};
      else nxt.phase = PH_DROP;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/strict_percent_decoder_unit.sv =====
// Strict percent decoder: input register, one decode step, output register.
// An accepted beat is decoded from the input register; its result is registered.
// One byte per cycle, as there is a single decode step, unless out_tready stalls.
// Synchronous active-low reset clears the escape state, query flag,
// plus-as-space register and both stage valids. Depends on spd_pkg, spd_decode.
`default_nettype none
module strict_percent_decoder_unit (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output      logic                       in_tready,
  input  wire logic [7:0]                 in_tdata,   // [7:0] in_byte
  input  wire logic                       in_tlast,
  output      logic                       out_tvalid,
  input  wire logic                       out_tready,
  output      logic [7:0]                 out_tdata,  // [7:0] out_byte
  output      logic                       out_tlast,
  output      logic                       out_tuser,  // [0] decode_error
  input  wire logic                       cfg_psel,
  input  wire logic                       cfg_penable,
  input  wire logic                       cfg_pwrite,
  input  wire logic [spd_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire logic [31:0]                cfg_pwdata,
  output      logic [31:0]                cfg_prdata,
  output      logic                       cfg_pready
);
  import spd_pkg::*;

  logic        plus_r;
  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        s1_last_r;
  dec_state_t  state_r, state_nxt;
  dec_result_t res;
  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  logic        out_last_r;
  logic        out_err_r;
  logic        out_free;
  logic        s1_adv;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = {31'd0, plus_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plus_r <= 1'b0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[CFG_AW-1] == REG_PLUS_SPACE) begin
      plus_r <= cfg_pwdata[0];
    end
  end

  spd_decode u_decode (
    .cur           (state_r),
    .in_byte       (s1_byte_r),
    .in_last       (s1_last_r),
    .plus_space_en (plus_r),
    .nxt           (state_nxt),
    .res           (res)
  );

  assign out_free  = !out_valid_r || out_tready;
  // a beat with no result can always move on
  assign s1_adv    = s1_valid_r && (out_free || !res.valid);
  assign in_tready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{phase: PH_NORMAL, high_nib: 4'd0, query_seen: 1'b0};
    end else if (s1_adv) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_adv && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_adv && res.valid) begin
      out_byte_r <= res.data;
      out_last_r <= res.last;
      out_err_r  <= res.err;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_err_r;

endmodule
`default_nettype wire

// ===== dv/spd_checker.sv =====
// Scoreboard for the strict percent decoder: watches the input, result and
// register ports, predicts every result beat and compares it field by field.
// Depends on spd_pkg for character codes, the phase enum and the register index.
`timescale 1ns / 100ps
module decoded_stream_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  input  logic                       in_tready,
  input  logic [7:0]                 in_tdata,   // [7:0] in_byte
  input  logic                       in_tlast,
  input  logic                       out_tvalid,
  input  logic                       out_tready,
  input  logic [7:0]                 out_tdata,  // [7:0] out_byte
  input  logic                       out_tlast,
  input  logic                       out_tuser,  // [0] decode_error
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [spd_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]                cfg_pwdata,
  input  logic                       cfg_pready,
  output int                         fail_count,
  output int                         pending,
  output int                         strings_seen,
  output int                         beats_seen,
  output int                         error_beats
);
  import spd_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       err;
  } dec_beat_t;

  dec_beat_t  expected_beats[$];
  phase_t     esc_phase;
  logic [3:0] hi_nibble;
  logic       query_on;
  logic       plus_to_space;

  // {is_digit, value}
  function automatic logic [4:0] digit_of(input logic [7:0] c);
    logic [7:0] off;
    if (c >= CHAR_0 && c <= CHAR_9) off = c - CHAR_0;
    else if (c >= CHAR_UA && c <= CHAR_UF) off = c - CHAR_UA + HEX_TEN;
    else if (c >= CHAR_LA && c <= CHAR_LF) off = c - CHAR_LA + HEX_TEN;
    else return 5'b0;
    return {1'b1, off[3:0]};
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    fail_count++;
  endtask

  task automatic clear_string();
    esc_phase = PH_NORMAL;
    hi_nibble = 4'd0;
    query_on  = 1'b0;
  endtask

  task automatic expect_beat(input logic [7:0] data, input logic last, input logic err);
    dec_beat_t b;
    b.data = data;
    b.last = last;
    b.err  = err;
    expected_beats.insert(expected_beats.size(), b);
  endtask

  task automatic escape_failed(input logic last);
    if (last) clear_string();
    else esc_phase = PH_DROP;
    expect_beat(8'h00, 1'b1, 1'b1);
  endtask

  task automatic decode_step(input logic [7:0] c, input logic last);
    logic [4:0] dg;
    logic [7:0] outc;
    dg = digit_of(c);
    outc = c;
    case (esc_phase)
      PH_DROP: begin
        if (last) clear_string();
      end
      PH_HIGH: begin
        if (!dg[4] || last) begin
          escape_failed(last);
        end else begin
          hi_nibble = dg[3:0];
          esc_phase = PH_LOW;
        end
      end
      PH_LOW: begin
        if (!dg[4]) begin
          escape_failed(last);
        end else begin
          expect_beat({hi_nibble, dg[3:0]}, last, 1'b0);
          esc_phase = PH_NORMAL;
          hi_nibble = 4'd0;
          if (last) clear_string();
        end
      end
      default: begin
        if (c == CHAR_PERCENT) begin
          if (last) escape_failed(1'b1);
          else esc_phase = PH_HIGH;
        end else begin
          if (c == CHAR_QUESTION) query_on = 1'b1;
          else if (c == CHAR_PLUS && query_on && plus_to_space) outc = CHAR_SPACE;
          expect_beat(outc, last, 1'b0);
          if (last) clear_string();
        end
      end
    endcase
  endtask

  always @(posedge clk) begin : watch
    dec_beat_t want;
    if (!rst_n) begin
      plus_to_space = 1'b0;
      clear_string();
      expected_beats.delete();
      pending <= 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr == {REG_PLUS_SPACE, 2'b00})
        plus_to_space = cfg_pwdata[0];
      if (in_tvalid && in_tready) begin
        decode_step(in_tdata, in_tlast);
        if (in_tlast) strings_seen++;
      end
      if (out_tvalid && out_tready) begin
        beats_seen++;
        if (out_tuser) error_beats++;
        if (expected_beats.size() == 0) begin
          report_mismatch($sformatf("unexpected beat data %02h last %0b err %0b",
                                    out_tdata, out_tlast, out_tuser));
        end else begin
          want = expected_beats.pop_front();
          if (out_tdata !== want.data)
            report_mismatch($sformatf("out_byte %02h, want %02h", out_tdata, want.data));
          if (out_tlast !== want.last)
            report_mismatch($sformatf("out_last %0b, want %0b", out_tlast, want.last));
          if (out_tuser !== want.err)
            report_mismatch($sformatf("decode_error %0b, want %0b", out_tuser, want.err));
        end
      end
      pending <= expected_beats.size();
    end
  end

endmodule

// ===== dv/tb.sv =====
// Top of the strict percent decoder testbench: clock, reset, stimulus and
// verdict. Uses decoded_stream_checker for prediction; depends on spd_pkg.
`timescale 1ns / 100ps
module tb;
  import spd_pkg::*;

  localparam int unsigned     PHASE_ITEMS   = 420;
  localparam int unsigned     SETTLE_CYCLES = 6;
  localparam int unsigned     MAX_IDLE      = 17;
  localparam longint unsigned LIMIT_NS      = 5_000_000;
  localparam logic [CFG_AW-1:0] ADDR_PLUS_SPACE = {REG_PLUS_SPACE, 2'b00};
  localparam logic [CFG_AW-1:0] ADDR_SPARE      = 3'd4;

  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              in_tvalid   = 1'b0;
  logic [7:0]        in_tdata    = 8'h00;
  logic              in_tlast    = 1'b0;
  logic              out_tready  = 1'b0;
  logic              cfg_psel    = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite  = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr   = '0;
  logic [31:0]       cfg_pwdata  = 32'h0;
  logic              in_tready;
  logic              out_tvalid;
  logic [7:0]        out_tdata;
  logic              out_tlast;
  logic              out_tuser;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  int fail_count, pending, strings_seen, beats_seen, error_beats;
  int unsigned bytes_sent = 0;
  logic        tx_steady  = 1'b0;
  logic        rx_steady  = 1'b0;
  int unsigned rx_hold    = 0;

  strict_percent_decoder_unit dut (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tlast,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast, .out_tuser,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_prdata, .cfg_pready
  );

  decoded_stream_checker checker_i (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tlast,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast, .out_tuser,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_pready,
    .fail_count, .pending, .strings_seen, .beats_seen, .error_beats
  );

  always #5 clk = ~clk;

  initial begin
    #(LIMIT_NS);
    $display("simulation failed");
    $finish;
  end

  function automatic int unsigned idle_draw(input logic steady);
    if (steady || $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(0, MAX_IDLE);
  endfunction

  // Receiver: stall for a drawn number of cycles after each result beat.
  always @(posedge clk) begin : rx_pace
    int unsigned hold_next;
    if (!rst_n) begin
      rx_hold    <= 0;
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if ($urandom_range(0, 15) == 0) rx_steady <= ~rx_steady;
        hold_next = idle_draw(rx_steady);
      end else begin
        hold_next = (rx_hold != 0) ? rx_hold - 1 : 0;
      end
      rx_hold    <= hold_next;
      out_tready <= (hold_next == 0);
    end
  end

  // Valid stays high after a beat, so it does not drop between back-to-back bytes.
  task automatic push_byte(input logic [7:0] b, input logic last);
    int unsigned gap;
    gap = idle_draw(tx_steady);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
  endtask

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], i == s.len() - 1);
  endtask

  // Hold the input until every predicted beat is back and the pipeline is empty.
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_AW-1:0] addr, input logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  function automatic logic [7:0] hex_char();
    logic [7:0] v;
    v = 8'($urandom_range(0, 15));
    if (v < HEX_TEN) return CHAR_0 + v;
    return ($urandom_range(0, 1) ? CHAR_UA : CHAR_LA) + v - HEX_TEN;
  endfunction

  function automatic logic [7:0] bad_digit();
    case ($urandom_range(0, 4))
      0:       return 8'($urandom_range(8'h00, 8'h2F));
      1:       return 8'($urandom_range(8'h3A, 8'h40));
      2:       return 8'($urandom_range(8'h47, 8'h60));
      3:       return 8'($urandom_range(8'h67, 8'hFF));
      default: return CHAR_QUESTION;
    endcase
  endfunction

  // Mostly well-formed strings; some with a bad or cut-off escape, some pure noise.
  task automatic random_string();
    logic [7:0]  body[$];
    logic [7:0]  c;
    int unsigned kind, tokens, cut;
    kind   = $urandom_range(0, 19);
    tokens = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 8);
    if ($urandom_range(0, 4) == 0) tx_steady = ~tx_steady;
    if (kind < 2) begin
      repeat (tokens) body.insert(body.size(), 8'($urandom_range(0, 255)));
    end else begin
      cut = (kind < 5) ? $urandom_range(0, tokens - 1) : tokens;
      for (int i = 0; i < tokens; i++) begin
        if (i == cut) begin
          body.insert(body.size(), CHAR_PERCENT);
          case ($urandom_range(0, 3))
            0: body.insert(body.size(), bad_digit());
            1: begin
              body.insert(body.size(), hex_char());
              body.insert(body.size(), bad_digit());
            end
            2: break;
            default: begin
              body.insert(body.size(), hex_char());
              break;
            end
          endcase
        end else begin
          case ($urandom_range(0, 9))
            0, 1, 2: begin
              c = 8'($urandom_range(0, 255));
              body.insert(body.size(), c == CHAR_PERCENT ? c ^ 8'h01 : c);
            end
            3, 4, 5: begin
              body.insert(body.size(), CHAR_PERCENT);
              body.insert(body.size(), hex_char());
              body.insert(body.size(), hex_char());
            end
            6:       body.insert(body.size(), CHAR_QUESTION);
            7, 8:    body.insert(body.size(), CHAR_PLUS);
            default: begin
              c = 8'($urandom_range(8'h20, 8'h7E));
              body.insert(body.size(), c == CHAR_PERCENT ? CHAR_PLUS : c);
            end
          endcase
        end
      end
    end
    foreach (body[i]) push_byte(body[i], i == body.size() - 1);
  endtask

  task automatic random_phase();
    int unsigned stop_at;
    stop_at = bytes_sent + PHASE_ITEMS;
    while (bytes_sent < stop_at) begin
      random_string();
      if ($urandom_range(0, 39) == 0) drain();
    end
    drain();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    cfg_write(ADDR_PLUS_SPACE, 32'h0000_0000);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b1);
    push_str("%4a%Fe");
    push_str("?+");     // plus stays a plus while the register is clear
    push_str("%");      // string ends on the escape opener
    push_str("%4");     // string ends after the first digit
    drain();

    cfg_write(ADDR_PLUS_SPACE, 32'hFFFF_FFFF);
    push_str("+?+");    // only the plus after the question mark turns to space
    push_str("%G1z");   // bad high digit, rest of the string dropped
    push_str("%?+");    // question mark in a digit slot is a bad digit
    push_str("%4?");    // bad low digit on the last byte
    push_str("?");
    push_str("+");      // query flag cleared by the previous string end
    drain();

    cfg_write(ADDR_SPARE, 32'h0000_0000);
    random_phase();
    cfg_write(ADDR_PLUS_SPACE, {$urandom() & 32'hFFFF_FFFE});
    random_phase();
    cfg_write(ADDR_PLUS_SPACE, {$urandom() | 32'h0000_0001});
    random_phase();
    cfg_write(ADDR_PLUS_SPACE, 32'h0000_0000);
    random_phase();

    $display("covered %0d bytes in %0d strings: %0d result beats, %0d of them decode errors",
             bytes_sent, strings_seen, beats_seen, error_beats);
    $display("plus-as-space cleared and set across phases, spare address written once");
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
